@@ design/lrt_pkg.sv @@
// Shared types and constants for the loss range tracker.
package lrt_pkg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [63:0] sample;
        logic [7:0]  reason;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EXTEND,
        OP_FOLD_STEP,
        OP_FOLD_APPLY,
        OP_APPEND,
        OP_SORT_STEP,
        OP_MERGE_STEP,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic clear_scan;
    } t_cmd;

    typedef struct packed {
        logic ext_hit;
        logic scan_last;
        logic pair_last;
        logic sort_done;
        logic merge_done;
        logic full;
        logic empty;
        logic few;
    } t_status;

endpackage

@@ design/lrt_ctrl.sv @@
// Controller state machine that sequences one transaction through the datapath.
module lrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_kind,
    input  logic             i_len_zero,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  lrt_pkg::t_status i_stat,
    output lrt_pkg::t_cmd    o_cmd,
    output logic             o_capture
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXT   = 3'd1;
    localparam logic [2:0] S_FOLD  = 3'd2;
    localparam logic [2:0] S_APP   = 3'd3;
    localparam logic [2:0] S_SORT  = 3'd4;
    localparam logic [2:0] S_MERGE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_FAPP  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_capture   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{op: lrt_pkg::OP_NONE, clear_scan: 1'b0};
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_capture) begin
                    o_cmd.clear_scan = 1'b1;
                    if (i_kind) begin
                        o_cmd.op    = lrt_pkg::OP_POP;
                        n_state     = S_DONE;
                    end else if (i_len_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_EXT;
                    end
                end
            end
            S_EXT: begin
                if (i_stat.empty) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.op = lrt_pkg::OP_EXTEND;
                    if (i_stat.ext_hit) begin
                        o_cmd.clear_scan = 1'b1;
                        n_state          = S_SORT;
                    end else if (i_stat.scan_last) begin
                        o_cmd.clear_scan = 1'b1;
                        n_state          = i_stat.full ? S_FOLD : S_APP;
                    end
                end
            end
            S_FOLD: begin
                if (i_stat.few) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.op = lrt_pkg::OP_FOLD_STEP;
                    if (i_stat.pair_last) begin
                        n_state = S_FAPP;
                    end
                end
            end
            S_FAPP: begin
                o_cmd.op = lrt_pkg::OP_FOLD_APPLY;
                n_state  = S_APP;
            end
            S_APP: begin
                o_cmd.op         = lrt_pkg::OP_APPEND;
                o_cmd.clear_scan = 1'b1;
                n_state          = S_SORT;
            end
            S_SORT: begin
                if (i_stat.sort_done) begin
                    o_cmd.clear_scan = 1'b1;
                    n_state          = S_MERGE;
                end else begin
                    o_cmd.op = lrt_pkg::OP_SORT_STEP;
                end
            end
            S_MERGE: begin
                if (i_stat.merge_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = lrt_pkg::OP_MERGE_STEP;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

@@ design/lrt_datapath.sv @@
// Entry table, scan counter, fold search and result registers.
module lrt_datapath #(
    parameter int SLOTS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_capture,
    input  logic             i_kind,
    input  logic [31:0]      i_start,
    input  logic [31:0]      i_length,
    input  logic [63:0]      i_sample,
    input  logic [7:0]       i_reason,
    input  logic [7:0]       i_silence,
    input  lrt_pkg::t_cmd    i_cmd,
    output lrt_pkg::t_status o_stat,
    output logic             o_taken,
    output logic [31:0]      o_out_start,
    output logic [31:0]      o_out_length,
    output logic [63:0]      o_out_sample,
    output logic [7:0]       o_out_reason,
    output logic [3:0]       o_pending,
    output logic [31:0]      o_records,
    output logic [31:0]      o_folded
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    lrt_pkg::t_entry r_tab [SLOTS];
    lrt_pkg::t_entry r_new;
    logic [CW-1:0]   r_cnt;
    logic [IW-1:0]   r_idx;
    logic            r_swapped;
    logic [IW-1:0]   r_best;
    logic [32:0]     r_min_cost;
    logic [31:0]     r_records, r_folded;
    logic            r_taken;
    lrt_pkg::t_entry r_out;

    lrt_pkg::t_entry cur, nxt;
    logic [IW-1:0]   idx1;
    logic [31:0]     cur_end, gap, fend;
    logic [32:0]     cost;
    logic            ext_fwd, ext_bwd;
    logic [CW-1:0]   idx1_w;

    assign idx1_w  = CW'(r_idx) + CW'(1);
    assign idx1    = idx1_w[IW-1:0];
    assign cur     = r_tab[r_idx];
    assign nxt     = (idx1_w < CW'(SLOTS)) ? r_tab[idx1] : '0;
    assign cur_end = cur.start + cur.length;
    assign gap     = (nxt.start > cur_end) ? nxt.start - cur_end : 32'd0;
    assign ext_fwd = (cur.reason == r_new.reason) && (cur_end == r_new.start);
    assign ext_bwd = (cur.reason == r_new.reason) && !ext_fwd
                     && (r_new.start + r_new.length == cur.start);

    always_comb begin
        cost = {1'b0, gap};
        if (cur.reason != nxt.reason) begin
            cost = cost + ((cur.reason == i_silence) ? {1'b0, cur.length}
                                                     : {1'b0, nxt.length});
        end
    end

    always_comb begin
        o_stat.ext_hit    = ext_fwd || ext_bwd;
        o_stat.scan_last  = (idx1_w >= r_cnt);
        o_stat.pair_last  = (idx1_w + CW'(1) >= r_cnt);
        o_stat.sort_done  = (idx1_w >= r_cnt) && !r_swapped;
        o_stat.merge_done = (idx1_w >= r_cnt) || (r_cnt < CW'(2));
        o_stat.full       = (r_cnt >= CW'(SLOTS));
        o_stat.empty      = (r_cnt == '0);
        o_stat.few        = (r_cnt < CW'(2));
    end

    lrt_pkg::t_entry fb, fa;
    logic [31:0]     fea, feb;
    assign fa   = r_tab[r_best];
    assign fb   = r_tab[r_best + IW'(1)];
    assign fea  = fa.start + fa.length;
    assign feb  = fb.start + fb.length;
    assign fend = (feb > fea) ? feb : fea;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) r_tab[k] <= '0;
            r_cnt     <= '0;
            r_records <= '0;
            r_folded  <= '0;
            r_idx     <= '0;
            r_swapped <= 1'b0;
            r_taken   <= 1'b0;
            r_out     <= '0;
            r_best    <= '0;
            r_min_cost <= '0;
        end else begin
            if (i_capture) begin
                r_new   <= '{start: i_start, length: i_length,
                             sample: i_sample, reason: i_reason};
                r_best  <= '0;
                r_min_cost <= '1;
                if (!i_kind) begin
                    r_taken <= 1'b0;
                    r_out   <= '0;
                end
            end
            if (i_cmd.clear_scan) begin
                r_idx     <= '0;
                r_swapped <= 1'b0;
            end
            unique case (i_cmd.op)
                lrt_pkg::OP_EXTEND: begin
                    if (ext_fwd) begin
                        r_tab[r_idx].length <= cur.length + r_new.length;
                    end else if (ext_bwd) begin
                        r_tab[r_idx].start  <= r_new.start;
                        r_tab[r_idx].sample <= r_new.sample;
                        r_tab[r_idx].length <= cur.length + r_new.length;
                    end else if (!i_cmd.clear_scan) begin
                        r_idx <= idx1;
                    end
                end
                lrt_pkg::OP_FOLD_STEP: begin
                    if (cost < r_min_cost) begin
                        r_min_cost <= cost;
                        r_best     <= r_idx;
                    end
                    r_idx <= idx1;
                end
                lrt_pkg::OP_FOLD_APPLY: begin
                    if (fa.reason == i_silence && fb.reason != i_silence) begin
                        r_tab[r_best].reason <= fb.reason;
                    end
                    r_tab[r_best].length <= fend - fa.start;
                    r_folded <= r_folded + r_min_cost[31:0];
                    for (int k = 0; k < SLOTS; k++) begin
                        if (k > int'(r_best)) begin
                            r_tab[k] <= (k + 1 < SLOTS) ? r_tab[(k + 1) % SLOTS] : '0;
                        end
                    end
                    r_cnt <= r_cnt - CW'(1);
                end
                lrt_pkg::OP_APPEND: begin
                    if (r_cnt < CW'(SLOTS)) begin
                        r_tab[r_cnt[IW-1:0]] <= r_new;
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_records <= r_records + 32'd1;
                end
                lrt_pkg::OP_SORT_STEP: begin
                    if (idx1_w >= r_cnt) begin
                        r_idx     <= '0;
                        r_swapped <= 1'b0;
                    end else begin
                        if (cur.start > nxt.start) begin
                            r_tab[r_idx] <= nxt;
                            r_tab[idx1]  <= cur;
                            r_swapped    <= 1'b1;
                        end
                        r_idx <= idx1;
                    end
                end
                lrt_pkg::OP_MERGE_STEP: begin
                    if (cur.reason == nxt.reason && cur_end == nxt.start) begin
                        r_tab[r_idx].length <= cur.length + nxt.length;
                        for (int k = 0; k < SLOTS; k++) begin
                            if (k > int'(r_idx)) begin
                                r_tab[k] <= (k + 1 < SLOTS) ? r_tab[(k + 1) % SLOTS] : '0;
                            end
                        end
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_idx <= idx1;
                    end
                end
                lrt_pkg::OP_POP: begin
                    if (r_cnt != '0) begin
                        r_taken <= 1'b1;
                        r_out   <= r_tab[0];
                        for (int k = 0; k < SLOTS; k++) begin
                            r_tab[k] <= (k + 1 < SLOTS) ? r_tab[(k + 1) % SLOTS] : '0;
                        end
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_taken <= 1'b0;
                        r_out   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_taken      = r_taken;
    assign o_out_start  = r_out.start;
    assign o_out_length = r_out.length;
    assign o_out_sample = r_out.sample;
    assign o_out_reason = r_out.reason;
    assign o_pending    = 4'(r_cnt);
    assign o_records    = r_records;
    assign o_folded     = r_folded;
endmodule

@@ design/loss_range_tracker_core.sv @@
// Top level of the loss range tracker: ports, configuration register and assertions.
// Usage: an input transaction on i_in_valid/o_in_ready carries kind, range start,
// length, sample and reason. kind 0 records a missing range, kind 1 pops the
// entry with the lowest start. Every input transaction yields one output
// transaction on o_out_valid/i_out_ready with the popped entry (or zeros), the
// pending entry count and the two running totals.
// A take or a zero-length record goes straight to the result; a record walks the
// table for extension, runs the fold search when nothing was extended and the
// table is full, appends the new entry unless one was extended, then
// bubble-sorts and merge-walks the table.
// One item is in flight at a time; the table scan through the shared compare unit
// sets this, and the next input transaction can be taken the cycle after delivery.
// Reset (synchronous, active low) empties the table and clears both totals
// and the silence reason code. A stalled receiver holds the result register and
// no new input transaction is taken until the result is delivered. The user must
// write the silence reason code via the configuration channel only while the block
// is idle; the block itself does not enforce this.
module loss_range_tracker_core #(
    parameter int SLOTS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_length,
    input  logic [63:0] i_range_sample,
    input  logic [7:0]  i_range_reason,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_taken,
    output logic [31:0] o_out_start,
    output logic [31:0] o_out_length,
    output logic [63:0] o_out_sample,
    output logic [7:0]  o_out_reason,
    output logic [3:0]  o_pending_entries,
    output logic [31:0] o_records_total,
    output logic [31:0] o_folded_total
);
    logic [7:0]       r_silence;
    lrt_pkg::t_cmd    cmd;
    lrt_pkg::t_status stat;
    logic             capture;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= '0;
        end else if (i_cfg_valid) begin
            r_silence <= i_cfg_data;
        end
    end

    lrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_len_zero  (i_range_length == 32'd0),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_capture   (capture)
    );

    lrt_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capture    (capture),
        .i_kind       (i_kind),
        .i_start      (i_range_start),
        .i_length     (i_range_length),
        .i_sample     (i_range_sample),
        .i_reason     (i_range_reason),
        .i_silence    (r_silence),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_taken      (o_taken),
        .o_out_start  (o_out_start),
        .o_out_length (o_out_length),
        .o_out_sample (o_out_sample),
        .o_out_reason (o_out_reason),
        .o_pending    (o_pending_entries),
        .o_records    (o_records_total),
        .o_folded     (o_folded_total)
    );

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input accepted while result pending");
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pending_entries <= 4'(SLOTS)) else $error("entry count beyond table size");
    a_taken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_taken) |-> (o_out_length == 32'd0))
        else $error("popped fields not cleared");
endmodule
